[design/rqsd_pkg.sv]
// Shared request/response types and codes for the reversible queue/stack deque.
package rqsd_pkg;

    localparam logic [2:0] REQ_URGENT  = 3'd0;
    localparam logic [2:0] REQ_NORMAL  = 3'd1;
    localparam logic [2:0] REQ_ADD     = 3'd2;
    localparam logic [2:0] REQ_PROCESS = 3'd3;
    localparam logic [2:0] REQ_STATUS  = 3'd4;

    localparam logic [1:0] RESP_POPPED = 2'd0;
    localparam logic [1:0] RESP_EMPTY  = 2'd1;
    localparam logic [1:0] RESP_STATUS = 2'd2;
    localparam logic [1:0] RESP_FULL   = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] job_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         resp_kind;
        logic signed [31:0] resp_value;
    } resp_t;

endpackage

[design/rqsd_ring.sv]
// Ring storage for jobs: one write port, one read port with registered read data.
module rqsd_ring #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [31:0]        wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [31:0]        rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read so a stalled item keeps its value.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/reversible_queue_stack_deque_top.sv]
// Top level of the reversible queue/stack deque.
// Results go through the p1 registers, then m_data_reg; m_ready can stall them.
// One item per cycle if not stalled; ring state and memory access update at accept.
// Items that cause no result (mode changes, successful adds) leave no output.
// aresetn (synchronous, active low) empties the store and selects normal mode;
// ring contents are not cleared and are never read before being written.
module reversible_queue_stack_deque_top
    import rqsd_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  req_t  s_data,
    output logic  m_valid,
    input  logic  m_ready,
    output resp_t m_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W:0] DEPTH_W = (PTR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Physical index of logical position pos given base and orientation.
    function automatic logic [PTR_W-1:0] ring_index(
        input logic [PTR_W-1:0] base,
        input logic             flip,
        input logic [PTR_W-1:0] pos
    );
        logic [PTR_W:0] acc;
        if (flip) begin
            acc = {1'b0, base} + DEPTH_W - {1'b0, pos};
        end else begin
            acc = {1'b0, base} + {1'b0, pos};
        end
        if (acc >= DEPTH_W) begin
            acc = acc - DEPTH_W;
        end
        return acc[PTR_W-1:0];
    endfunction

    logic [PTR_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             flip_reg, flip_next;
    logic             urgent_reg, urgent_next;

    logic             wr_en, rd_en;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    logic [31:0]      rd_data;
    logic             res_valid;
    logic [1:0]       res_kind;

    logic             p1_valid_reg;
    logic [1:0]       p1_kind_reg;
    logic [CNT_W-1:0] p1_count_reg;

    logic             m_valid_reg;
    resp_t            m_data_reg;

    logic             accept, out_free, advance;
    logic [CNT_W-1:0] count_m1;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign count_m1 = count_reg - CNT_W'(1);

    always_comb begin
        base_next   = base_reg;
        count_next  = count_reg;
        flip_next   = flip_reg;
        urgent_next = urgent_reg;
        wr_en       = 1'b0;
        wr_addr     = ring_index(base_reg, flip_reg, count_reg[PTR_W-1:0]);
        rd_en       = 1'b0;
        rd_addr     = ring_index(base_reg, flip_reg, count_m1[PTR_W-1:0]);
        res_valid   = 1'b0;
        res_kind    = RESP_POPPED;
        unique case (s_data.req_type)
            REQ_URGENT: begin
                urgent_next = 1'b1;
            end
            REQ_NORMAL: begin
                if (urgent_reg) begin
                    urgent_next = 1'b0;
                    // Reverse the list: back becomes front, walk the other way.
                    if (count_reg != '0) begin
                        base_next = ring_index(base_reg, flip_reg, count_m1[PTR_W-1:0]);
                        flip_next = !flip_reg;
                    end
                end
            end
            REQ_ADD: begin
                if (count_reg >= DEPTH_C) begin
                    res_valid = 1'b1;
                    res_kind  = RESP_FULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_PROCESS: begin
                res_valid = 1'b1;
                if (count_reg == '0) begin
                    res_kind = RESP_EMPTY;
                end else begin
                    rd_en      = 1'b1;
                    count_next = count_m1;
                    if (!urgent_reg) begin
                        rd_addr   = base_reg;
                        base_next = ring_index(base_reg, flip_reg, PTR_W'(1));
                    end
                end
            end
            REQ_STATUS: begin
                res_valid = 1'b1;
                res_kind  = RESP_STATUS;
            end
            default: begin
                // Unused codes: ignore.
            end
        endcase
    end

    rqsd_ring #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (accept && wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.job_value),
        .rd_en   (accept && rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            count_reg  <= '0;
            flip_reg   <= 1'b0;
            urgent_reg <= 1'b0;
        end else if (accept) begin
            base_reg   <= base_next;
            count_reg  <= count_next;
            flip_reg   <= flip_next;
            urgent_reg <= urgent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= res_valid;
        end else if (advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_kind_reg  <= res_kind;
            p1_count_reg <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg.resp_kind <= p1_kind_reg;
            unique case (p1_kind_reg)
                RESP_POPPED: m_data_reg.resp_value <= rd_data;
                RESP_STATUS: m_data_reg.resp_value <= 32'(p1_count_reg);
                default:     m_data_reg.resp_value <= '0;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the reversible queue/stack deque: directed table plus random traffic.
`timescale 1ns / 1ps

module tb_top
    import rqsd_pkg::*;
();

    localparam int DEPTH      = 16;
    localparam int RAND_ITEMS = 1170;
    localparam int STALL_LIMIT = 1000;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] val;
        int                 reps;
        bit                 typed;
        logic [1:0]         kind;
        logic signed [31:0] rval;
    } plan_row_t;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    req_t  s_data;
    logic  m_valid;
    logic  m_ready;
    resp_t m_data;

    // Shadow copy of the job ring
    logic signed [31:0] ring [DEPTH];
    logic [3:0]         front_idx;
    logic [4:0]         held;
    logic               reversed;
    logic               stack_mode;

    resp_t     pending_resp [$];
    plan_row_t plan [$];
    int        src_idle;
    int        dst_idle;
    int        errors = 0;
    int        stall_cnt;

    reversible_queue_stack_deque_top #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic logic [3:0] ring_slot(input logic [4:0] pos);
        if (reversed) begin
            ring_slot = front_idx - pos[3:0];
        end else begin
            ring_slot = front_idx + pos[3:0];
        end
    endfunction

    // Apply one request to the shadow deque; has_resp tells whether a result follows.
    task automatic deque_apply(input req_t it, output bit has_resp, output resp_t res);
        logic [3:0] idx;
        has_resp = 1'b0;
        res      = '0;
        case (it.req_type)
            REQ_URGENT: begin
                stack_mode = 1'b1;
            end
            REQ_NORMAL: begin
                if (stack_mode) begin
                    // reverse the list: the old back becomes the front
                    if (held != 0) begin
                        front_idx = ring_slot(held - 5'd1);
                        reversed  = !reversed;
                    end
                    stack_mode = 1'b0;
                end
            end
            REQ_ADD: begin
                if (held >= DEPTH) begin
                    has_resp = 1'b1;
                    res.resp_kind = RESP_FULL;
                end else begin
                    ring[ring_slot(held)] = it.job_value;
                    held = held + 5'd1;
                end
            end
            REQ_PROCESS: begin
                has_resp = 1'b1;
                if (held == 0) begin
                    res.resp_kind = RESP_EMPTY;
                end else begin
                    if (stack_mode) begin
                        idx = ring_slot(held - 5'd1);
                    end else begin
                        idx = ring_slot(5'd0);
                        front_idx = ring_slot(5'd1);
                    end
                    held = held - 5'd1;
                    res.resp_kind  = RESP_POPPED;
                    res.resp_value = ring[idx];
                end
            end
            REQ_STATUS: begin
                has_resp = 1'b1;
                res.resp_kind  = RESP_STATUS;
                res.resp_value = 32'(held);
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input req_t it);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Send one item and queue what the shadow deque says should come back.
    task automatic issue(input req_t it);
        bit    has_resp;
        resp_t res;
        send_item(it);
        deque_apply(it, has_resp, res);
        if (has_resp) pending_resp.push_back(res);
    endtask

    task automatic add_row(input logic [2:0] op, input logic signed [31:0] val, input int reps,
                           input bit typed, input logic [1:0] kind,
                           input logic signed [31:0] rval);
        plan_row_t r;
        r.op    = op;
        r.val   = val;
        r.reps  = reps;
        r.typed = typed;
        r.kind  = kind;
        r.rval  = rval;
        plan.push_back(r);
    endtask

    function automatic logic signed [31:0] pick_job();
        case ($urandom_range(0, 7))
            0:       pick_job = 32'sh7FFF_FFFF;
            1:       pick_job = 32'sh8000_0000;
            2:       pick_job = 32'sh0;
            3:       pick_job = -32'sd1;
            default: pick_job = $urandom();
        endcase
    endfunction

    // Response checker and stall watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= dst_idle);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cnt <= 0;
            end else begin
                stall_cnt <= stall_cnt + 1;
                if (stall_cnt + 1 >= STALL_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
            if (m_valid && m_ready) begin
                if (pending_resp.size() == 0) begin
                    $error("unexpected result: resp_kind %0d resp_value %0d",
                           m_data.resp_kind, m_data.resp_value);
                    errors = errors + 1;
                end else begin
                    if (m_data.resp_kind !== pending_resp[0].resp_kind) begin
                        $error("resp_kind: expected %0d, actual %0d",
                               pending_resp[0].resp_kind, m_data.resp_kind);
                        errors = errors + 1;
                    end
                    if (m_data.resp_value !== pending_resp[0].resp_value) begin
                        $error("resp_value: expected %0d, actual %0d",
                               pending_resp[0].resp_value, m_data.resp_value);
                        errors = errors + 1;
                    end
                    void'(pending_resp.pop_front());
                end
            end
        end
    end

    initial begin
        req_t      it;
        resp_t     typed_res;
        bit        has_resp;
        resp_t     res;
        bit        fill_bias;
        int        burst_left;
        int        done;
        int        roll;
        int        phase;

        src_idle   = 15;
        dst_idle   = 66;
        front_idx  = '0;
        held       = '0;
        reversed   = 1'b0;
        stack_mode = 1'b0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;

        // directed: extremes, every request, mode corner cases, full and empty
        add_row(REQ_STATUS,  0, 1, 1, RESP_STATUS, 0);
        add_row(REQ_PROCESS, 0, 1, 1, RESP_EMPTY, 0);
        add_row(REQ_ADD, 32'sh7FFF_FFFF, 1, 0, RESP_POPPED, 0);
        add_row(REQ_ADD, 32'sh8000_0000, 1, 0, RESP_POPPED, 0);
        add_row(REQ_ADD, -32'sd1, 1, 0, RESP_POPPED, 0);
        add_row(REQ_PROCESS, 0, 1, 0, RESP_POPPED, 0);
        add_row(REQ_URGENT,  0, 1, 0, RESP_POPPED, 0);
        add_row(REQ_URGENT,  0, 1, 0, RESP_POPPED, 0);
        add_row(REQ_PROCESS, 0, 1, 0, RESP_POPPED, 0);
        add_row(REQ_ADD,     5, 1, 0, RESP_POPPED, 0);
        add_row(REQ_NORMAL,  0, 1, 0, RESP_POPPED, 0);
        add_row(REQ_NORMAL,  0, 1, 0, RESP_POPPED, 0);
        add_row(REQ_PROCESS, 0, 2, 0, RESP_POPPED, 0);
        add_row(REQ_PROCESS, 0, 1, 1, RESP_EMPTY, 0);
        add_row(REQ_URGENT,  0, 1, 0, RESP_POPPED, 0);
        add_row(REQ_NORMAL,  0, 1, 0, RESP_POPPED, 0);
        add_row(REQ_ADD, 32'sh1000, DEPTH, 0, RESP_POPPED, 0);
        add_row(REQ_ADD, 32'h5A5A_A5A5, 1, 1, RESP_FULL, 0);
        add_row(REQ_STATUS,  0, 1, 1, RESP_STATUS, DEPTH);
        add_row(REQ_URGENT,  0, 1, 0, RESP_POPPED, 0);
        add_row(REQ_NORMAL,  0, 1, 0, RESP_POPPED, 0);
        add_row(REQ_PROCESS, 0, 3, 0, RESP_POPPED, 0);
        add_row(3'd5, 32'hFFFF_FFFF, 1, 0, RESP_POPPED, 0);
        add_row(3'd6, 0, 1, 0, RESP_POPPED, 0);
        add_row(3'd7, 32'h5555_5555, 1, 0, RESP_POPPED, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            for (int k = 0; k < plan[i].reps; k++) begin
                it.req_type  = plan[i].op;
                it.job_value = plan[i].val + k;
                if (plan[i].typed) begin
                    send_item(it);
                    deque_apply(it, has_resp, res);
                    typed_res.resp_kind  = plan[i].kind;
                    typed_res.resp_value = plan[i].rval;
                    pending_resp.push_back(typed_res);
                end else begin
                    issue(it);
                end
            end
        end

        // random: bursts biased toward filling or draining so both ends get hit
        burst_left = 0;
        fill_bias  = 1'b1;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle = 15; dst_idle = 66; end
                1: begin src_idle = 66; dst_idle = 15; end
                default: begin src_idle = 0; dst_idle = 0; end
            endcase
            done = 0;
            while (done < RAND_ITEMS / 3) begin
                if (burst_left == 0) begin
                    fill_bias  = $urandom_range(0, 1);
                    burst_left = $urandom_range(10, 40);
                end
                burst_left--;
                roll = $urandom_range(0, 99);
                it.job_value = pick_job();
                if (fill_bias) begin
                    if (roll < 60)      it.req_type = REQ_ADD;
                    else if (roll < 75) it.req_type = REQ_PROCESS;
                    else if (roll < 85) it.req_type = REQ_STATUS;
                    else if (roll < 91) it.req_type = REQ_URGENT;
                    else if (roll < 97) it.req_type = REQ_NORMAL;
                    else                it.req_type = 3'($urandom_range(5, 7));
                end else begin
                    if (roll < 20)      it.req_type = REQ_ADD;
                    else if (roll < 65) it.req_type = REQ_PROCESS;
                    else if (roll < 80) it.req_type = REQ_STATUS;
                    else if (roll < 88) it.req_type = REQ_URGENT;
                    else if (roll < 96) it.req_type = REQ_NORMAL;
                    else                it.req_type = 3'($urandom_range(5, 7));
                end
                issue(it);
                if (it.req_type <= REQ_STATUS) done++;
            end
        end
        s_valid <= 1'b0;

        while (pending_resp.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/rqsd_pkg.sv
design/rqsd_ring.sv
design/reversible_queue_stack_deque_top.sv
test/tb_top.sv
